>>> rtl/brfps_pkg.sv
// Package: ring depth, command codes, config register indices, request/result structs and FSM state type.
package brfps_pkg;

  // storage slots in the byte store; field widths are sized for this depth
  localparam int DEPTH = 1024;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_DROP  = 3'd3,
    CMD_CLEAR = 3'd4,
    CMD_FIND  = 3'd5
  } cmd_e;

  localparam logic [1:0] REG_RING_SIZE = 2'd0;
  localparam logic [1:0] REG_PAT_BYTES = 2'd1;
  localparam logic [1:0] REG_PAT_LEN   = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  data_in;
    logic [9:0]  offset;
    logic [10:0] drop_count;
  } req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       ok;
    logic [9:0] match_pos;
    logic [9:0] used_count;
    logic [9:0] free_count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_FCHK,
    ST_FCMP,
    ST_DONE
  } state_e;

endpackage

>>> rtl/byte_ring_fifo_peek_search_unit.sv
// Top level: byte ring FIFO with peek, drop, clear and pattern find over one RAM.
// Push, drop, clear and bad commands pass through RD and DONE; a pop or peek that succeeds adds FCMP.
// Find walks FCHK and FCMP for each compared byte, then DONE; a zero length goes straight to DONE.
// busy is high from the accepted request through the result strobe; the next request
// is taken the cycle after the strobe, so a new request is taken only once the last is done.
// Reset clears head, tail and config (ring_size 1024, pattern 0, length 1), not the RAM.
module byte_ring_fifo_peek_search_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  brfps_pkg::req_t    req_i,
  output logic               result_valid_o,
  output brfps_pkg::rsp_t    result_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i
);

  localparam int AW = $clog2(brfps_pkg::DEPTH);
  localparam int CW = AW + 1;

  // config registers
  logic [10:0] ring_size_q;
  logic [63:0] pat_q;
  logic [3:0]  plen_q;

  // ring state
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  brfps_pkg::state_e st_q, st_d;
  brfps_pkg::req_t   req_q, req_d;
  brfps_pkg::rsp_t   rsp_q, rsp_d;

  // find walk
  logic [CW-1:0] s_q, s_d;
  logic [3:0]    k_q, k_d;

  // memory
  logic [7:0]    mem [brfps_pkg::DEPTH];
  logic [7:0]    rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;

  // effective ring size, clamped to 2..DEPTH
  logic [CW-1:0] sz;
  always_comb begin
    if (ring_size_q < 11'd2) sz = CW'(2);
    else if ({5'd0, ring_size_q} > 16'(brfps_pkg::DEPTH)) sz = CW'(brfps_pkg::DEPTH);
    else sz = CW'(ring_size_q);
  end

  // pointers normalized into the active ring
  logic [AW-1:0] hd, tl;
  assign hd = ({1'b0, head_q} >= sz) ? '0 : head_q;
  assign tl = ({1'b0, tail_q} >= sz) ? '0 : tail_q;

  logic [CW-1:0] used;
  assign used = (tl >= hd) ? CW'(tl - hd) : CW'(sz - CW'(hd) + CW'(tl));

  // head-relative slot: rel below sz assumed, one compare and subtract
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] rel,
                                         input logic [CW-1:0] size);
    logic [CW:0] p;
    p = {1'b0, CW'(h)} + {1'b0, rel};
    if (p >= {1'b0, size}) p = p - {1'b0, size};
    return AW'(p);
  endfunction

  logic [AW-1:0] inc_tl, inc_hd;
  assign inc_tl = (CW'(tl) + CW'(1) == sz) ? '0 : AW'(tl + 1'b1);
  assign inc_hd = (CW'(hd) + CW'(1) == sz) ? '0 : AW'(hd + 1'b1);

  logic [3:0] plen;
  assign plen = (plen_q > 4'd8) ? 4'd8 : plen_q;

  logic [7:0] pbyte;
  assign pbyte = pat_q[8*k_q[2:0] +: 8];

  logic [CW-1:0] off_ext;
  assign off_ext = CW'(req_q.offset);

  // final counts from next pointers
  function automatic brfps_pkg::rsp_t fill_counts(input brfps_pkg::rsp_t r,
      input logic [AW-1:0] h, input logic [AW-1:0] t, input logic [CW-1:0] size);
    logic [CW-1:0] u;
    u = (t >= h) ? CW'(t - h) : CW'(size - CW'(h) + CW'(t));
    r.used_count = 10'(u);
    r.free_count = 10'(size - CW'(1) - u);
    return r;
  endfunction

  // FSM
  always_comb begin
    st_d   = st_q;
    head_d = head_q;
    tail_d = tail_q;
    req_d  = req_q;
    rsp_d  = rsp_q;
    s_d    = s_q;
    k_d    = k_q;
    we     = 1'b0;
    waddr  = tl;
    raddr  = hd;
    case (st_q)
      brfps_pkg::ST_IDLE: begin
        if (start) begin
          req_d = req_i;
          st_d  = brfps_pkg::ST_RD;
        end
      end
      brfps_pkg::ST_RD: begin
        rsp_d  = '0;
        head_d = hd;
        tail_d = tl;
        st_d   = brfps_pkg::ST_DONE;
        case (req_q.cmd)
          brfps_pkg::CMD_PUSH: begin
            if (used < sz - CW'(1)) begin
              we       = 1'b1;
              tail_d   = inc_tl;
              rsp_d.ok = 1'b1;
            end
          end
          brfps_pkg::CMD_POP: begin
            raddr = hd;
            if (used != '0) begin
              head_d   = inc_hd;
              rsp_d.ok = 1'b1;
              st_d     = brfps_pkg::ST_FCMP;
              k_d      = 4'd0;
            end
          end
          brfps_pkg::CMD_PEEK: begin
            raddr = slot(hd, off_ext, sz);
            if (off_ext < used) begin
              rsp_d.ok = 1'b1;
              st_d     = brfps_pkg::ST_FCMP;
              k_d      = 4'd0;
            end
          end
          brfps_pkg::CMD_DROP: begin
            if (CW'(req_q.drop_count) > used) head_d = tl;
            else head_d = slot(hd, CW'(req_q.drop_count), sz);
            rsp_d.ok = 1'b1;
          end
          brfps_pkg::CMD_CLEAR: begin
            head_d   = tl;
            rsp_d.ok = 1'b1;
          end
          brfps_pkg::CMD_FIND: begin
            s_d  = off_ext;
            k_d  = 4'd0;
            st_d = (plen == 4'd0) ? brfps_pkg::ST_DONE : brfps_pkg::ST_FCHK;
          end
          default: ;
        endcase
      end
      // find: check start fits, then issue read of byte k
      brfps_pkg::ST_FCHK: begin
        if ({1'b0, s_q} + {{(CW-3){1'b0}}, plen} > {1'b0, used}) begin
          st_d = brfps_pkg::ST_DONE;
        end else begin
          raddr = slot(hd, s_q + CW'(k_q), sz);
          st_d  = brfps_pkg::ST_FCMP;
        end
      end
      // compare returned byte (or capture pop/peek byte)
      brfps_pkg::ST_FCMP: begin
        if (req_q.cmd != brfps_pkg::CMD_FIND) begin
          rsp_d.read_byte = rdata_q;
          st_d = brfps_pkg::ST_DONE;
        end else if (rdata_q != pbyte) begin
          s_d  = s_q + CW'(1);
          k_d  = 4'd0;
          st_d = brfps_pkg::ST_FCHK;
        end else if (k_q + 4'd1 == plen) begin
          rsp_d.ok        = 1'b1;
          rsp_d.match_pos = 10'(s_q);
          st_d            = brfps_pkg::ST_DONE;
        end else begin
          k_d  = k_q + 4'd1;
          st_d = brfps_pkg::ST_FCHK;
        end
      end
      brfps_pkg::ST_DONE: begin
        rsp_d = fill_counts(rsp_q, hd, tl, sz);
        st_d  = brfps_pkg::ST_IDLE;
      end
      default: st_d = brfps_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= brfps_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      ring_size_q <= 11'd1024;
      pat_q       <= '0;
      plen_q      <= 4'd1;
    end else begin
      st_q <= st_d;
      if (cfg_we_i && cfg_idx_i == brfps_pkg::REG_RING_SIZE) begin
        ring_size_q <= cfg_wdata_i[10:0];
        head_q      <= '0;
        tail_q      <= '0;
      end else begin
        head_q <= head_d;
        tail_q <= tail_d;
      end
      if (cfg_we_i && cfg_idx_i == brfps_pkg::REG_PAT_BYTES) pat_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == brfps_pkg::REG_PAT_LEN) plen_q <= cfg_wdata_i[3:0];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    s_q   <= s_d;
    k_q   <= k_d;
  end

  // byte store
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= req_q.data_in;
    rdata_q <= mem[raddr];
  end

  assign busy           = (st_q != brfps_pkg::ST_IDLE);
  assign result_valid_o = (st_q == brfps_pkg::ST_DONE);
  assign result_o       = fill_counts(rsp_q, hd, tl, sz);

  // a result strobe is always followed by idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy) else $error("result not followed by idle");
  // a start in idle enters processing
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");
  // used plus free equals capacity
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (CW'(result_o.used_count) + CW'(result_o.free_count) == sz - CW'(1)))
    else $error("count mismatch");
endmodule

>>> verif/tb.sv
// Testbench for the byte ring FIFO with peek, drop, clear and pattern find.
module tb;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            start;
  logic            busy;
  brfps_pkg::req_t req_i;
  logic            result_valid_o;
  brfps_pkg::rsp_t result_o;
  logic            cfg_we_i;
  logic [1:0]      cfg_idx_i;
  logic [63:0]     cfg_wdata_i;

  // Predicted FIFO contents and settings
  logic [7:0]  ring_mem [1024];
  int          head_ptr, tail_ptr;
  logic [10:0] ring_size_q;
  logic [63:0] pattern_q;
  logic [3:0]  pattern_len_q;

  brfps_pkg::rsp_t pending_rsps[$];
  int              error_cnt;
  int              sender_idle_pct;

  byte_ring_fifo_peek_search_unit u_top (
    .clk_i, .rst_ni, .start, .busy, .req_i, .result_valid_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #24000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int ring_slots();
    if (ring_size_q < 2) return 2;
    if (ring_size_q > 1024) return 1024;
    return int'(ring_size_q);
  endfunction

  function automatic int fill_level();
    int sz;
    sz = ring_slots();
    if (head_ptr >= sz) head_ptr = 0;
    if (tail_ptr >= sz) tail_ptr = 0;
    return (tail_ptr >= head_ptr) ? tail_ptr - head_ptr : sz - head_ptr + tail_ptr;
  endfunction

  // Expected response of the FIFO to one request; updates predicted state
  function automatic brfps_pkg::rsp_t fifo_response(brfps_pkg::req_t r);
    int              sz, used, plen, s, k;
    logic            hit;
    brfps_pkg::rsp_t o;
    o = '0;
    sz = ring_slots();
    used = fill_level();
    case (brfps_pkg::cmd_e'(r.cmd))
      brfps_pkg::CMD_PUSH: if (used < sz - 1) begin
        ring_mem[tail_ptr] = r.data_in;
        tail_ptr = (tail_ptr + 1 == sz) ? 0 : tail_ptr + 1;
        o.ok = 1'b1;
      end
      brfps_pkg::CMD_POP: if (used != 0) begin
        o.read_byte = ring_mem[head_ptr];
        head_ptr = (head_ptr + 1 == sz) ? 0 : head_ptr + 1;
        o.ok = 1'b1;
      end
      brfps_pkg::CMD_PEEK: if (int'(r.offset) < used) begin
        o.read_byte = ring_mem[(head_ptr + int'(r.offset)) % sz];
        o.ok = 1'b1;
      end
      brfps_pkg::CMD_DROP: begin
        if (int'(r.drop_count) > used) head_ptr = tail_ptr;
        else head_ptr = (head_ptr + int'(r.drop_count)) % sz;
        o.ok = 1'b1;
      end
      brfps_pkg::CMD_CLEAR: begin
        head_ptr = tail_ptr;
        o.ok = 1'b1;
      end
      brfps_pkg::CMD_FIND: begin
        plen = (pattern_len_q > 8) ? 8 : int'(pattern_len_q);
        if (plen != 0) begin
          for (s = int'(r.offset); s + plen <= used && !o.ok; s++) begin
            hit = 1'b1;
            for (k = 0; k < plen; k++)
              if (ring_mem[(head_ptr + s + k) % sz] != pattern_q[8*k +: 8]) hit = 1'b0;
            if (hit) begin
              o.ok = 1'b1;
              o.match_pos = s[9:0];
            end
          end
        end
      end
      default: ;
    endcase
    used = fill_level();
    o.used_count = used[9:0];
    o.free_count = 10'(sz - 1 - used);
    return o;
  endfunction

  // Response checker: the block cannot be stalled, so every strobe is taken
  always @(posedge clk_i) begin
    brfps_pkg::rsp_t exp_rsp;
    if (rst_ni && result_valid_o) begin
      if (pending_rsps.size() == 0) begin
        $display("%0t: unexpected response %h", $time, result_o);
        error_cnt++;
      end else begin
        exp_rsp = pending_rsps.pop_front();
        if (result_o.read_byte !== exp_rsp.read_byte ||
            result_o.ok !== exp_rsp.ok ||
            result_o.match_pos !== exp_rsp.match_pos ||
            result_o.used_count !== exp_rsp.used_count ||
            result_o.free_count !== exp_rsp.free_count) begin
          $display("%0t: mismatch exp byte=%h ok=%b pos=%0d used=%0d free=%0d", $time,
                   exp_rsp.read_byte, exp_rsp.ok, exp_rsp.match_pos,
                   exp_rsp.used_count, exp_rsp.free_count);
          $display("%0t:          got byte=%h ok=%b pos=%0d used=%0d free=%0d", $time,
                   result_o.read_byte, result_o.ok, result_o.match_pos,
                   result_o.used_count, result_o.free_count);
          error_cnt++;
        end
      end
    end
  end

  // Issue one request; start stays high afterwards unless a gap is drawn
  task automatic send_req(brfps_pkg::req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pending_rsps.push_back(fifo_response(r));
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
  endtask

  task automatic send_cmd(brfps_pkg::cmd_e c, logic [7:0] d = 8'h00, logic [9:0] off = '0,
                          logic [10:0] cnt = '0);
    brfps_pkg::req_t r;
    r.cmd = c;
    r.data_in = d;
    r.offset = off;
    r.drop_count = cnt;
    send_req(r);
  endtask

  // Register write once all responses are in
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    start <= 1'b0;
    do @(posedge clk_i); while (pending_rsps.size() != 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      brfps_pkg::REG_RING_SIZE: begin
        ring_size_q = val[10:0];
        head_ptr = 0;
        tail_ptr = 0;
      end
      brfps_pkg::REG_PAT_BYTES: pattern_q = val;
      brfps_pkg::REG_PAT_LEN: pattern_len_q = val[3:0];
      default: ;
    endcase
  endtask

  // Pattern of bytes from a small alphabet so finds hit often
  function automatic logic [63:0] small_pattern();
    logic [63:0] p;
    for (int k = 0; k < 8; k++) p[8*k +: 8] = 8'($urandom_range(0, 3));
    return p;
  endfunction

  task automatic test_directed();
    sender_idle_pct = 0;
    write_reg(brfps_pkg::REG_RING_SIZE, 64'd4);
    write_reg(brfps_pkg::REG_PAT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(brfps_pkg::CMD_POP);                       // pop on empty
    send_cmd(brfps_pkg::CMD_PEEK);                      // peek on empty
    send_cmd(brfps_pkg::CMD_FIND);
    send_cmd(brfps_pkg::CMD_PUSH, 8'h00);
    send_cmd(brfps_pkg::CMD_PUSH, 8'hFF);
    send_cmd(brfps_pkg::CMD_PUSH, 8'h55);
    send_cmd(brfps_pkg::CMD_PUSH, 8'hAA);               // full: refused
    send_cmd(brfps_pkg::CMD_PEEK, 8'h00, 10'd2);
    send_cmd(brfps_pkg::CMD_PEEK, 8'h00, 10'd3);        // past valid bytes
    send_cmd(brfps_pkg::CMD_PEEK, 8'h00, 10'h3FF);
    send_cmd(brfps_pkg::CMD_FIND, 8'h00, 10'd0);
    send_cmd(brfps_pkg::CMD_FIND, 8'h00, 10'd2);        // start beyond the match
    send_cmd(brfps_pkg::cmd_e'(3'd6));
    send_cmd(brfps_pkg::cmd_e'(3'd7), 8'hFF, 10'h3FF, 11'h7FF);
    send_cmd(brfps_pkg::CMD_POP);
    send_cmd(brfps_pkg::CMD_DROP, 8'h00, 10'd0, 11'd0);
    send_cmd(brfps_pkg::CMD_DROP, 8'h00, 10'd0, 11'd1);
    send_cmd(brfps_pkg::CMD_PUSH, 8'h12);
    send_cmd(brfps_pkg::CMD_DROP, 8'h00, 10'd0, 11'h7FF); // more than held
    send_cmd(brfps_pkg::CMD_PUSH, 8'hFF);
    send_cmd(brfps_pkg::CMD_CLEAR);
    send_cmd(brfps_pkg::CMD_PUSH, 8'hFF);
    write_reg(brfps_pkg::REG_PAT_LEN, 64'd0);           // zero length never matches
    send_cmd(brfps_pkg::CMD_FIND);
    write_reg(brfps_pkg::REG_PAT_LEN, 64'd15);          // above eight acts as eight
    send_cmd(brfps_pkg::CMD_FIND);
    write_reg(2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(brfps_pkg::CMD_PEEK);
  endtask

  // Random phase: mostly pushes and reads, byte values from a small alphabet
  task automatic test_random(int n_items, int idle_pct, logic [10:0] rsize, int plen);
    brfps_pkg::req_t r;
    int              w, used;
    write_reg(brfps_pkg::REG_RING_SIZE, 64'(rsize));
    write_reg(brfps_pkg::REG_PAT_BYTES, small_pattern());
    write_reg(brfps_pkg::REG_PAT_LEN, 64'(plen));
    sender_idle_pct = idle_pct;
    for (int i = 0; i < n_items; i++) begin
      used = fill_level();
      w = $urandom_range(0, 99);
      r.data_in = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      r.offset = ($urandom_range(0, 7) != 0) ? 10'($urandom_range(0, used + 2))
                                              : 10'($urandom);
      r.drop_count = ($urandom_range(0, 3) != 0) ? 11'($urandom_range(0, used + 1))
                                                  : 11'($urandom);
      if (w < 42)      r.cmd = brfps_pkg::CMD_PUSH;
      else if (w < 56) r.cmd = brfps_pkg::CMD_POP;
      else if (w < 72) r.cmd = brfps_pkg::CMD_PEEK;
      else if (w < 77) r.cmd = brfps_pkg::CMD_DROP;
      else if (w < 79) r.cmd = brfps_pkg::CMD_CLEAR;
      else if (w < 98) r.cmd = brfps_pkg::CMD_FIND;
      else             r.cmd = 3'($urandom_range(6, 7));
      send_req(r);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    error_cnt = 0;
    sender_idle_pct = 0;
    head_ptr = 0;
    tail_ptr = 0;
    ring_size_q = 11'd1024;
    pattern_q = '0;
    pattern_len_q = 4'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(200, 0, 11'd16, 2);
    test_random(180, 88, 11'd8, 1);
    test_random(150, 37, 11'd1024, 3);
    test_random(180, 0, 11'd40, 2);
    test_random(100, 37, 11'd2, 1);
    test_random(100, 88, 11'd0, 1);
    test_random(80, 0, 11'h7FF, 8);
    test_random(60, 37, 11'd5, 4);

    start <= 1'b0;
    do @(posedge clk_i); while (pending_rsps.size() != 0);
    repeat (20) @(posedge clk_i);
    if (error_cnt == 0 && pending_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/brfps_pkg.sv
rtl/byte_ring_fifo_peek_search_unit.sv
verif/tb.sv
